>>> rtl/pfr_pkg.sv
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int MAX_ROOTS = 32;
  localparam int NUM_CELLS = MAX_ROOTS + 1;
  localparam int DEG_W     = $clog2(MAX_ROOTS + 1);

  localparam int ROOT_W    = 32;
  localparam int COEF_W    = 64;
  localparam int POWER_W   = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  localparam logic [COEF_W-1:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [COEF_W-1:0] COEF_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ABS,
    CELL_LO,
    CELL_HI,
    CELL_SUM,
    CELL_WR,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic                r_neg;
    logic [ROOT_W-1:0]   r_mag;
  } cell_ctrl_t;

endpackage

>>> rtl/polynomial_from_roots.sv
`timescale 1ns / 1ps

// Builds prod(x - r) from a stream of Q16.16 roots and emits its Q32.32
// coefficients.
// Input channel s_axis: one root per request, tlast marks the final root.
// Output channel m_axis: one request per coefficient, constant term first
// up to the leading 1.0; tdata carries value and power, tlast flags the
// leading coefficient, tuser the sticky overflow/dropped-root flag.
// A row of cells, one per power of x, updates all coefficients at once.
// Each cell shares one 32x32 multiplier over two passes, so a root passes
// through the accept state plus abs, low product, high product, round
// and saturating update. A root beyond capacity is dropped when accepted.
// After the final root, degree+1 results follow, one per cycle while
// m_axis_tready is high; the cells shift down toward cell 0 on each
// taken request. A stall simply holds the current result. No root is
// taken while results are pending. After the leading coefficient is taken
// the block returns to the constant polynomial 1.0. Reset gives the same
// state at once; there is no clearing pass.

module polynomial_from_roots (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pfr_pkg::IN_DATA_W-1:0] s_axis_tdata,  // [31:0] root_value
  input  logic                          s_axis_tlast,  // last_root
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] coef_value, [69:64] coef_power, [71:70] zero
  output logic [pfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,  // last_coef
  output logic                          m_axis_tuser   // overflow
);
  import pfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_LO,
    ST_HI,
    ST_SUM,
    ST_WR,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [DEG_W-1:0]    degree_q;
  logic [DEG_W-1:0]    emit_cnt_q;
  logic                sticky_q;
  logic                last_q;
  logic                r_neg_q;
  logic [ROOT_W-1:0]   r_mag_q;

  cell_ctrl_t          ctrl;
  logic [COEF_W-1:0]   coef   [NUM_CELLS];
  logic [NUM_CELLS-1:0] cell_ovf;

  logic                in_req;
  logic                out_req;
  logic                at_top;
  logic                full_deg;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign in_req   = s_axis_tvalid && s_axis_tready;
  assign out_req  = m_axis_tvalid && m_axis_tready;
  assign at_top   = (emit_cnt_q == degree_q);
  assign full_deg = (degree_q == DEG_W'(MAX_ROOTS));

  always_comb begin
    ctrl.r_neg = r_neg_q;
    ctrl.r_mag = r_mag_q;
    unique case (state_q)
      ST_ABS:  ctrl.op = CELL_ABS;
      ST_LO:   ctrl.op = CELL_LO;
      ST_HI:   ctrl.op = CELL_HI;
      ST_SUM:  ctrl.op = CELL_SUM;
      ST_WR:   ctrl.op = CELL_WR;
      ST_EMIT: ctrl.op = !out_req ? CELL_HOLD : (at_top ? CELL_CLEAR : CELL_SHIFT);
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    pfr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .init_i  ((k == 0) ? ONE_Q32 : COEF_W'(0)),
      .lower_i ((k == 0) ? COEF_W'(0) : coef[(k == 0) ? 0 : k - 1]),
      .upper_i ((k == NUM_CELLS - 1) ? COEF_W'(0)
                                     : coef[(k == NUM_CELLS - 1) ? k : k + 1]),
      .coef_o  (coef[k]),
      .ovf_o   (cell_ovf[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      degree_q   <= '0;
      emit_cnt_q <= '0;
      sticky_q   <= 1'b0;
      last_q     <= 1'b0;
      r_neg_q    <= 1'b0;
      r_mag_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_req) begin
            last_q  <= s_axis_tlast;
            r_neg_q <= s_axis_tdata[ROOT_W-1];
            r_mag_q <= s_axis_tdata[ROOT_W-1] ? (ROOT_W'(0) - s_axis_tdata[ROOT_W-1:0])
                                              : s_axis_tdata[ROOT_W-1:0];
            if (full_deg) begin
              sticky_q <= 1'b1;
              if (s_axis_tlast) begin
                state_q <= ST_EMIT;
              end
            end else begin
              state_q <= ST_ABS;
            end
          end
        end
        ST_ABS: state_q <= ST_LO;
        ST_LO:  state_q <= ST_HI;
        ST_HI:  state_q <= ST_SUM;
        ST_SUM: state_q <= ST_WR;
        ST_WR: begin
          sticky_q <= sticky_q | (|cell_ovf);
          degree_q <= degree_q + DEG_W'(1);
          state_q  <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_req) begin
            if (at_top) begin
              degree_q   <= '0;
              emit_cnt_q <= '0;
              sticky_q   <= 1'b0;
              state_q    <= ST_IDLE;
            end else begin
              emit_cnt_q <= emit_cnt_q + DEG_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, POWER_W'(emit_cnt_q), coef[0]};
  assign m_axis_tlast = at_top;
  assign m_axis_tuser = sticky_q;

endmodule

>>> rtl/pfr_cell.sv
`timescale 1ns / 1ps

module pfr_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pfr_pkg::cell_ctrl_t       ctrl_i,
  input  logic [pfr_pkg::COEF_W-1:0] init_i,
  input  logic [pfr_pkg::COEF_W-1:0] lower_i,
  input  logic [pfr_pkg::COEF_W-1:0] upper_i,
  output logic [pfr_pkg::COEF_W-1:0] coef_o,
  output logic                      ovf_o
);
  import pfr_pkg::*;

  logic [COEF_W-1:0]   coef_q;
  logic [COEF_W-1:0]   mag_q;
  logic                pneg_q;
  logic [COEF_W-1:0]   plo_q;
  logic [COEF_W-1:0]   phi_q;
  logic [COEF_W-1:0]   rnd_q;
  logic                big_q;

  logic [31:0]         mul_a;
  logic [COEF_W-1:0]   mul;
  logic [95:0]         full;
  logic                prod_neg;
  logic [COEF_W+1:0]   c_ext;
  logic [COEF_W+1:0]   p_ext;
  logic [COEF_W+1:0]   res_ext;
  logic                wr_ovf;
  logic [COEF_W-1:0]   wr_val;

  // one 32x32 multiplier, low half of |prev| first, then high half
  assign mul_a = (ctrl_i.op == CELL_HI) ? mag_q[63:32] : mag_q[31:0];
  assign mul   = {32'h0, mul_a} * {32'h0, ctrl_i.r_mag};

  // rounded magnitude of (|prev| * |r|) >> 16, ties away from zero
  assign full = {phi_q, 32'h0} + {32'h0, plo_q} + 96'h8000;

  assign prod_neg = ctrl_i.r_neg ^ pneg_q;
  assign c_ext    = {{2{lower_i[COEF_W-1]}}, lower_i};
  assign p_ext    = {2'b00, rnd_q};
  assign res_ext  = prod_neg ? (c_ext + p_ext) : (c_ext - p_ext);

  always_comb begin
    wr_ovf = 1'b0;
    wr_val = res_ext[COEF_W-1:0];
    if (big_q) begin
      wr_ovf = 1'b1;
      wr_val = prod_neg ? COEF_MAX : COEF_MIN;
    end else if ((res_ext[COEF_W+1] != res_ext[COEF_W]) ||
                 (res_ext[COEF_W] != res_ext[COEF_W-1])) begin
      wr_ovf = 1'b1;
      wr_val = res_ext[COEF_W+1] ? COEF_MIN : COEF_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= init_i;
    end else begin
      unique case (ctrl_i.op)
        CELL_WR:    coef_q <= wr_val;
        CELL_SHIFT: coef_q <= upper_i;
        CELL_CLEAR: coef_q <= init_i;
        default:    coef_q <= coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      CELL_ABS: begin
        pneg_q <= coef_q[COEF_W-1];
        mag_q  <= coef_q[COEF_W-1] ? (COEF_W'(0) - coef_q) : coef_q;
      end
      CELL_LO:  plo_q <= mul;
      CELL_HI:  phi_q <= mul;
      CELL_SUM: begin
        big_q <= (full[95:80] != 16'h0);
        rnd_q <= full[79:16];
      end
      default: ;
    endcase
  end

  assign coef_o = coef_q;
  assign ovf_o  = (ctrl_i.op == CELL_WR) && wr_ovf;

endmodule

>>> rtl/pfr_checker.sv
`timescale 1ns / 1ps

module pfr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tuser
);
  import pfr_pkg::*;

  logic out_req;
  assign out_req = m_axis_tvalid && m_axis_tready;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("roots taken while results pending");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_first_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (m_axis_tdata[69:64] == POWER_W'(0)))
    else $error("emission does not start at the constant term");

  a_power_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req && !m_axis_tlast |=> m_axis_tvalid &&
      (m_axis_tdata[69:64] == $past(m_axis_tdata[69:64]) + POWER_W'(1)))
    else $error("coefficient power out of sequence");

  a_end_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("block did not return to idle after leading coefficient");

endmodule

bind polynomial_from_roots pfr_checker u_pfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/polynomial_from_roots_test.sv
`timescale 1ns / 1ps

module polynomial_from_roots_test;
  import pfr_pkg::*;

  localparam int          NUM_RANDOM_ROOTS = 250;
  localparam int          RX_HOLD_CYCLES   = 300;
  localparam int          QUIET_LIMIT      = 4000;
  localparam int          TAIL_CYCLES      = 20;
  localparam logic [63:0] BIAS             = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [COEF_W-1:0]  value;
    logic [POWER_W-1:0] power;
    logic               last;
    logic               ovf;
  } coef_result_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              last;
    logic [7:0]        count;
    logic              typed;
    logic [COEF_W-1:0] const_coef;
    logic              ovf;
  } root_row_t;

  localparam int NUM_ROWS = 17;
  localparam root_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{32'h0001_0000, 1'b1, 8'd1,  1'b1, 64'hFFFF_FFFF_0000_0000, 1'b0},
    '{32'h0000_0000, 1'b1, 8'd1,  1'b1, 64'h0000_0000_0000_0000, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 8'd1,  1'b1, 64'hFFFF_8000_0001_0000, 1'b0},
    '{32'h8000_0000, 1'b1, 8'd1,  1'b1, 64'h0000_8000_0000_0000, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 8'd1,  1'b0, 64'h0,                   1'b0},
    '{32'h0000_0001, 1'b1, 8'd1,  1'b0, 64'h0,                   1'b0},
    '{32'h0002_0000, 1'b0, 8'd1,  1'b0, 64'h0,                   1'b0},
    '{32'hFFFF_0000, 1'b1, 8'd1,  1'b0, 64'h0,                   1'b0},
    // (x + 32768)^3 saturates
    '{32'h8000_0000, 1'b0, 8'd2,  1'b0, 64'h0,                   1'b0},
    '{32'h8000_0000, 1'b1, 8'd1,  1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1},
    // sticky flag cleared after emission
    '{32'h0000_0000, 1'b1, 8'd1,  1'b1, 64'h0000_0000_0000_0000, 1'b0},
    // full capacity, then a dropped final root
    '{32'h0001_0000, 1'b0, 8'd32, 1'b0, 64'h0,                   1'b0},
    '{32'h0001_0000, 1'b1, 8'd1,  1'b1, 64'h0000_0001_0000_0000, 1'b1},
    // rounding ties, both signs
    '{32'h0000_0001, 1'b0, 8'd2,  1'b0, 64'h0,                   1'b0},
    '{32'h0000_8000, 1'b1, 8'd1,  1'b0, 64'h0,                   1'b0},
    '{32'h0000_0001, 1'b0, 8'd2,  1'b0, 64'h0,                   1'b0},
    '{32'hFFFF_8000, 1'b1, 8'd1,  1'b0, 64'h0,                   1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  logic [COEF_W-1:0] poly_coefs [NUM_CELLS];
  int unsigned       poly_degree;
  logic              poly_ovf;
  coef_result_t      coef_expect_q [$];

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  rx_hold = 1'b0;
  int  mismatches = 0;
  int  roots_sent = 0;
  int  polys_sent = 0;
  int  roots_dropped = 0;
  int  coefs_seen = 0;
  int  ovf_seen = 0;

  polynomial_from_roots dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // c - r * prev, Q32.32, rounded half away from zero on magnitude, saturated
  function automatic logic [COEF_W-1:0] coef_update(input logic [COEF_W-1:0] c,
                                                   input logic [COEF_W-1:0] prev,
                                                   input logic [ROOT_W-1:0] r,
                                                   inout logic ovf);
    logic              prod_neg;
    logic [ROOT_W-1:0] m_r;
    logic [COEF_W-1:0] m_p;
    logic [COEF_W-1:0] u;
    logic [127:0]      prod;
    logic [COEF_W:0]   sum;
    m_r      = r[ROOT_W-1] ? -r : r;
    m_p      = prev[COEF_W-1] ? -prev : prev;
    prod_neg = r[ROOT_W-1] ^ prev[COEF_W-1];
    prod     = ({64'b0, m_p} * {96'b0, m_r} + 128'h8000) >> 16;
    u        = c ^ BIAS;
    if (prod[127:64] != '0) begin
      ovf = 1'b1;
      return prod_neg ? COEF_MAX : COEF_MIN;
    end
    if (!prod_neg) begin
      if (prod[63:0] > u) begin
        ovf = 1'b1;
        return COEF_MIN;
      end
      return (u - prod[63:0]) ^ BIAS;
    end
    sum = {1'b0, u} + {1'b0, prod[63:0]};
    if (sum[COEF_W]) begin
      ovf = 1'b1;
      return COEF_MAX;
    end
    return sum[COEF_W-1:0] ^ BIAS;
  endfunction

  function automatic void clear_poly();
    foreach (poly_coefs[i]) poly_coefs[i] = '0;
    poly_coefs[0] = ONE_Q32;
    poly_degree   = 0;
    poly_ovf      = 1'b0;
  endfunction

  // folds one root into the held polynomial; on the final root queues the
  // coefficients, optionally with a hand-computed constant term
  function automatic void expand_root(input logic [ROOT_W-1:0] r, input logic last,
                                      input logic typed, input logic [COEF_W-1:0] t_coef,
                                      input logic t_ovf);
    logic [COEF_W-1:0] prev [NUM_CELLS];
    coef_result_t      res;
    if (poly_degree >= MAX_ROOTS) begin
      poly_ovf = 1'b1;
      roots_dropped++;
    end else begin
      prev = poly_coefs;
      for (int j = 1; j <= poly_degree + 1; j++)
        poly_coefs[j] = coef_update(prev[j], prev[j-1], r, poly_ovf);
      poly_degree++;
    end
    if (last) begin
      for (int k = 0; k <= poly_degree; k++) begin
        res.value = poly_coefs[poly_degree - k];
        res.power = POWER_W'(k);
        res.last  = (k == poly_degree);
        res.ovf   = poly_ovf;
        if (typed && k == 0) begin
          res.value = t_coef;
          res.ovf   = t_ovf;
        end
        coef_expect_q = {coef_expect_q, res};
      end
      polys_sent++;
      clear_poly();
    end
  endfunction

  task automatic send_root(input logic [ROOT_W-1:0] r, input logic last,
                           input logic typed, input logic [COEF_W-1:0] t_coef,
                           input logic t_ovf);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    roots_sent++;
    expand_root(r, last, typed, t_coef, t_ovf);
  endtask

  function automatic logic [ROOT_W-1:0] pick_root();
    logic [ROOT_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        v = $urandom_range(0, 32'h0008_0000);
        v = v - 32'h0004_0000;
      end
      5, 6, 7: v = $urandom;
      8: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int          len;
    int          rnd_sent;
    logic        hold_done;
    root_row_t   row;
    clear_poly();
    tx_idle_pct = 18;
    rx_idle_pct = 80;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      for (int n = 0; n < row.count; n++)
        send_root(row.root, row.last, row.typed, row.const_coef, row.ovf);
    end

    rnd_sent  = 0;
    hold_done = 1'b0;
    while (rnd_sent < NUM_RANDOM_ROOTS) begin
      if (rnd_sent >= 2 * NUM_RANDOM_ROOTS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        if (!hold_done) begin
          rx_hold   = 1'b1;
          hold_done = 1'b1;
        end
      end else if (rnd_sent >= NUM_RANDOM_ROOTS / 3) begin
        tx_idle_pct = 80;
        rx_idle_pct = 18;
      end
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
      for (int n = 0; n < len; n++) begin
        send_root(pick_root(), n == len - 1, 1'b0, '0, 1'b0);
        rnd_sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (coef_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb: %0d roots (%0d dropped) in %0d polynomials, %0d coefficients checked",
             roots_sent, roots_dropped, polys_sent, coefs_seen);
    $display("tb: %0d coefficients carried the overflow flag", ovf_seen);
    if (mismatches == 0 && coef_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : coef_check
    coef_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      coefs_seen++;
      if (m_axis_tuser) ovf_seen++;
      if (coef_expect_q.size() == 0) begin
        $error("coefficient with none expected: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = coef_expect_q.pop_front();
        if (m_axis_tdata[63:0] !== want.value) begin
          $error("coef_value: expected %h, got %h", want.value, m_axis_tdata[63:0]);
          mismatches++;
        end
        if (m_axis_tdata[69:64] !== want.power) begin
          $error("coef_power: expected %0d, got %0d", want.power, m_axis_tdata[69:64]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_coef: expected %b, got %b", want.last, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser !== want.ovf) begin
          $error("overflow: expected %b, got %b", want.ovf, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
